FILE: sv/deq_pkg.sv
package deq_pkg;

   localparam int ENTRIES    = 16;
   localparam int DATA_WIDTH = 32;

   // Field widths of the channels
   localparam int OP_W     = 3;
   localparam int WORD_W   = 32;
   localparam int POS_W    = 4;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam int PTR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int OFF_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
   localparam logic [OP_W-1:0] OP_READ       = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic latch_req;
      logic execute;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } stat_type;

   // Ring slot of an offset from the head; offset stays below ENTRIES when used
   function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
                                               input logic [OFF_W-1:0] offset);
      logic [OFF_W:0] sum;
      sum = (OFF_W + 1)'(head) + (OFF_W + 1)'(offset);
      if (sum >= (OFF_W + 1)'(ENTRIES)) begin
         sum = sum - (OFF_W + 1)'(ENTRIES);
      end
      return PTR_W'(sum);
   endfunction

endpackage

FILE: sv/double_ended_queue.sv
// Double-ended queue of 16 words of 32 bits, kept in a ring store.
// Request channel (req_valid / req_stall): req_op selects push back,
// push front, pop back, pop front or read at req_position (counted from
// the front); req_data_in is the word stored by a push.
// Response channel (rsp_valid / rsp_stall): one item per request with
// rsp_data_out (popped or read word, zero otherwise), rsp_status (ok,
// empty on pop, position out of range, full on push) and rsp_count,
// the element count after the operation.
// The controller runs one request at a time through latch, execute
// (single-port store access and pointer update) and output load, so a new
// request is not accepted before the last one has reached the load step.
// The next request is accepted while a finished response waits in the
// output register; a stalled receiver holds the response there and the
// following response waits in the load step until the register frees.
// Reset (synchronous, active high) empties the queue and the response
// register; store contents are not cleared and are unreachable until
// written by a push.
module double_ended_queue (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [deq_pkg::OP_W-1:0]           req_op,
   input  logic [deq_pkg::WORD_W-1:0]         req_data_in,
   input  logic [deq_pkg::POS_W-1:0]          req_position,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [deq_pkg::WORD_W-1:0]         rsp_data_out,
   output logic [deq_pkg::STATUS_W-1:0]       rsp_status,
   output logic [deq_pkg::COUNT_W-1:0]        rsp_count
);

   deq_pkg::cmd_type  cmd;
   deq_pkg::stat_type stat;

   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   deq_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_op       (req_op),
      .req_data_in  (req_data_in),
      .req_position (req_position),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data_out (rsp_data_out),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count)
   );

endmodule

FILE: sv/deq_ctrl.sv
module deq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output deq_pkg::cmd_type   cmd,
   input  deq_pkg::stat_type  stat
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_LOAD = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = reset | (state_ff != S_IDLE);
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            // hold until the output register can take the item
            if (stat.out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.latch_req = accept;
      cmd.execute   = (state_ff == S_EXEC);
      cmd.load_out  = (state_ff == S_LOAD) & stat.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_EXEC)
      else $error("accepted item did not start execution");

   a_exec_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXEC |=> state_ff == S_LOAD)
      else $error("execution did not move to load");

   a_load_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD && !stat.out_free) |=> state_ff == S_LOAD)
      else $error("result left load while output register busy");

endmodule

FILE: sv/deq_datapath.sv
module deq_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  deq_pkg::cmd_type                     cmd,
   output deq_pkg::stat_type                    stat,
   input  logic [deq_pkg::OP_W-1:0]             req_op,
   input  logic [deq_pkg::WORD_W-1:0]           req_data_in,
   input  logic [deq_pkg::POS_W-1:0]            req_position,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [deq_pkg::WORD_W-1:0]           rsp_data_out,
   output logic [deq_pkg::STATUS_W-1:0]         rsp_status,
   output logic [deq_pkg::COUNT_W-1:0]          rsp_count
);

   logic [deq_pkg::DATA_WIDTH-1:0] mem [deq_pkg::ENTRIES];

   // latched request
   logic [deq_pkg::OP_W-1:0]       op_ff;
   logic [deq_pkg::DATA_WIDTH-1:0] wdata_ff;
   logic [deq_pkg::POS_W-1:0]      pos_ff;

   // queue pointers
   logic [deq_pkg::PTR_W-1:0] head_ff, head_in;
   logic [deq_pkg::CNT_W-1:0] count_ff, count_in;

   // execution results
   logic [deq_pkg::DATA_WIDTH-1:0] rd_data_ff;
   logic                           rd_ok_ff, rd_ok_in;
   logic [deq_pkg::STATUS_W-1:0]   status_ff, status_in;

   // output register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [deq_pkg::WORD_W-1:0]     rsp_data_ff;
   logic [deq_pkg::STATUS_W-1:0]   rsp_status_ff;
   logic [deq_pkg::COUNT_W-1:0]    rsp_count_ff;

   logic                      wr_en, rd_en;
   logic [deq_pkg::PTR_W-1:0] addr;
   logic                      full, empty;

   assign full  = (count_ff >= deq_pkg::CNT_W'(deq_pkg::ENTRIES));
   assign empty = (count_ff == '0);

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      status_in = deq_pkg::ST_OK;
      rd_ok_in  = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      addr      = head_ff;
      case (op_ff)
         deq_pkg::OP_PUSH_BACK: begin
            if (full) begin
               status_in = deq_pkg::ST_FULL;
            end else begin
               addr     = deq_pkg::slot_of(head_ff, deq_pkg::OFF_W'(count_ff));
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         deq_pkg::OP_PUSH_FRONT: begin
            if (full) begin
               status_in = deq_pkg::ST_FULL;
            end else begin
               addr     = deq_pkg::slot_of(head_ff, deq_pkg::OFF_W'(deq_pkg::ENTRIES - 1));
               wr_en    = 1'b1;
               head_in  = addr;
               count_in = count_ff + 1'b1;
            end
         end
         deq_pkg::OP_POP_BACK: begin
            if (empty) begin
               status_in = deq_pkg::ST_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
               addr     = deq_pkg::slot_of(head_ff, deq_pkg::OFF_W'(count_in));
               rd_en    = 1'b1;
               rd_ok_in = 1'b1;
            end
         end
         deq_pkg::OP_POP_FRONT: begin
            if (empty) begin
               status_in = deq_pkg::ST_EMPTY;
            end else begin
               addr     = head_ff;
               rd_en    = 1'b1;
               rd_ok_in = 1'b1;
               head_in  = deq_pkg::slot_of(head_ff, deq_pkg::OFF_W'(1));
               count_in = count_ff - 1'b1;
            end
         end
         deq_pkg::OP_READ: begin
            if (deq_pkg::OFF_W'(pos_ff) >= deq_pkg::OFF_W'(count_ff)) begin
               status_in = deq_pkg::ST_RANGE;
            end else begin
               addr     = deq_pkg::slot_of(head_ff, deq_pkg::OFF_W'(pos_ff));
               rd_en    = 1'b1;
               rd_ok_in = 1'b1;
            end
         end
         default: begin
            // unknown operation: ignore
         end
      endcase
   end

   assign stat.out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && wr_en) begin
         mem[addr] <= wdata_ff;
      end
      if (cmd.execute && rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff    <= req_op;
         wdata_ff <= deq_pkg::DATA_WIDTH'(req_data_in);
         pos_ff   <= req_position;
      end
      if (cmd.execute) begin
         status_ff <= status_in;
         rd_ok_ff  <= rd_ok_in;
      end
      if (cmd.load_out) begin
         rsp_data_ff   <= rd_ok_ff ? deq_pkg::WORD_W'(rd_data_ff) : '0;
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= deq_pkg::COUNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.execute) begin
            head_ff  <= head_in;
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_count    = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= deq_pkg::CNT_W'(deq_pkg::ENTRIES))
      else $error("element count above capacity");

   a_ptr_stable: assert property (@(posedge clock) disable iff (reset)
      !cmd.execute |=> ($stable(count_ff) && $stable(head_ff)))
      else $error("pointers changed outside execution");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || !rsp_stall))
      else $error("output register overwritten while stalled");

endmodule

FILE: dv/double_ended_queue_test.sv
module double_ended_queue_test;

   localparam int MAX_WAIT     = 8;
   localparam int RANDOM_ITEMS = 1750;
   localparam int IDLE_LIMIT   = 400;
   localparam int DRAIN_CYCLES = 12;
   localparam int POS_MAX      = (1 << deq_pkg::POS_W) - 1;

   // Op codes the block ignores
   localparam logic [deq_pkg::OP_W-1:0] OP_SPARE_LO = deq_pkg::OP_READ + 1'b1;
   localparam logic [deq_pkg::OP_W-1:0] OP_SPARE_HI = '1;

   typedef struct {
      logic [deq_pkg::OP_W-1:0]   op;
      logic [deq_pkg::WORD_W-1:0] word;
      logic [deq_pkg::POS_W-1:0]  pos;
   } deq_request_type;

   typedef struct packed {
      logic [deq_pkg::WORD_W-1:0]   data;
      logic [deq_pkg::STATUS_W-1:0] status;
      logic [deq_pkg::COUNT_W-1:0]  count;
   } deq_answer_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [deq_pkg::OP_W-1:0]     req_op = '0;
   logic [deq_pkg::WORD_W-1:0]   req_data_in = '0;
   logic [deq_pkg::POS_W-1:0]    req_position = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [deq_pkg::WORD_W-1:0]   rsp_data_out;
   logic [deq_pkg::STATUS_W-1:0] rsp_status;
   logic [deq_pkg::COUNT_W-1:0]  rsp_count;

   deq_request_type requests_left[$];
   deq_answer_type  answers_due[$];
   int              errors = 0;
   int              plan_count = 0;

   int req_gap = 0;
   int rsp_wait = 0;
   bit req_burst = 1'b0;
   bit rsp_burst = 1'b0;

   // Shadow deque
   logic [deq_pkg::DATA_WIDTH-1:0] deq_words[deq_pkg::ENTRIES];
   logic [deq_pkg::PTR_W-1:0]      deq_head = '0;
   logic [deq_pkg::CNT_W-1:0]      deq_count = '0;

   double_ended_queue u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_data_in  (req_data_in),
      .req_position (req_position),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data_out (rsp_data_out),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic deq_answer_type deq_apply(input logic [deq_pkg::OP_W-1:0] op,
                                                input logic [deq_pkg::WORD_W-1:0] word,
                                                input logic [deq_pkg::POS_W-1:0] pos);
      deq_answer_type            ans;
      logic [deq_pkg::PTR_W-1:0] slot;
      ans = '0;
      case (op)
         deq_pkg::OP_PUSH_BACK: begin
            if (deq_count >= deq_pkg::ENTRIES) begin
               ans.status = deq_pkg::ST_FULL;
            end else begin
               slot = deq_pkg::PTR_W'((int'(deq_head) + int'(deq_count)) % deq_pkg::ENTRIES);
               deq_words[slot] = word[deq_pkg::DATA_WIDTH-1:0];
               deq_count++;
            end
         end
         deq_pkg::OP_PUSH_FRONT: begin
            if (deq_count >= deq_pkg::ENTRIES) begin
               ans.status = deq_pkg::ST_FULL;
            end else begin
               deq_head = deq_pkg::PTR_W'((int'(deq_head) + deq_pkg::ENTRIES - 1)
                                          % deq_pkg::ENTRIES);
               deq_words[deq_head] = word[deq_pkg::DATA_WIDTH-1:0];
               deq_count++;
            end
         end
         deq_pkg::OP_POP_BACK: begin
            if (deq_count == 0) begin
               ans.status = deq_pkg::ST_EMPTY;
            end else begin
               deq_count--;
               slot = deq_pkg::PTR_W'((int'(deq_head) + int'(deq_count)) % deq_pkg::ENTRIES);
               ans.data = deq_pkg::WORD_W'(deq_words[slot]);
            end
         end
         deq_pkg::OP_POP_FRONT: begin
            if (deq_count == 0) begin
               ans.status = deq_pkg::ST_EMPTY;
            end else begin
               ans.data = deq_pkg::WORD_W'(deq_words[deq_head]);
               deq_head = deq_pkg::PTR_W'((int'(deq_head) + 1) % deq_pkg::ENTRIES);
               deq_count--;
            end
         end
         deq_pkg::OP_READ: begin
            if (int'(pos) >= int'(deq_count)) begin
               ans.status = deq_pkg::ST_RANGE;
            end else begin
               slot = deq_pkg::PTR_W'((int'(deq_head) + int'(pos)) % deq_pkg::ENTRIES);
               ans.data = deq_pkg::WORD_W'(deq_words[slot]);
            end
         end
         default: begin
         end
      endcase
      ans.count = deq_pkg::COUNT_W'(deq_count);
      return ans;
   endfunction

   function automatic int draw_wait(input bit burst);
      return burst ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   // Track the count as the stimulus is planned, to aim reads at held positions
   task automatic add_request(input logic [deq_pkg::OP_W-1:0] op,
                              input logic [deq_pkg::WORD_W-1:0] word,
                              input logic [deq_pkg::POS_W-1:0] pos);
      deq_request_type item;
      item.op   = op;
      item.word = word;
      item.pos  = pos;
      requests_left.push_back(item);
      if ((op == deq_pkg::OP_PUSH_BACK || op == deq_pkg::OP_PUSH_FRONT) &&
          plan_count < deq_pkg::ENTRIES) begin
         plan_count++;
      end else if ((op == deq_pkg::OP_POP_BACK || op == deq_pkg::OP_POP_FRONT) &&
                   plan_count > 0) begin
         plan_count--;
      end
   endtask

   always @(posedge clock) begin : drive_req
      deq_request_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            answers_due.push_back(deq_apply(req_op, req_data_in, req_position));
            if ($urandom_range(0, 49) == 0) begin
               req_burst = !req_burst;
            end
            req_gap = draw_wait(req_burst);
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (requests_left.size() > 0) begin
               nxt = requests_left.pop_front();
               req_op       <= nxt.op;
               req_data_in  <= nxt.word;
               req_position <= nxt.pos;
               req_valid    <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_rsp
      deq_answer_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               $display("%0t: unexpected item: data %h status %0d count %0d",
                        $time, rsp_data_out, rsp_status, rsp_count);
               errors++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_data_out !== want.data) begin
                  $display("%0t: rsp_data_out expected %h actual %h",
                           $time, want.data, rsp_data_out);
                  errors++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: rsp_status expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  errors++;
               end
               if (rsp_count !== want.count) begin
                  $display("%0t: rsp_count expected %0d actual %0d",
                           $time, want.count, rsp_count);
                  errors++;
               end
            end
            if ($urandom_range(0, 49) == 0) begin
               rsp_burst = !rsp_burst;
            end
            rsp_wait = draw_wait(rsp_burst);
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_stall <= (rsp_wait > 0);
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      logic [deq_pkg::WORD_W-1:0] edge_words[4];
      logic [deq_pkg::POS_W-1:0]  pos;
      bit                         filling;
      int                         r;

      edge_words[0] = '0;
      edge_words[1] = '1;
      edge_words[2] = 32'haaaa_aaaa;
      edge_words[3] = 32'h5555_5555;

      // Empty queue: both pops and a read fail, spare ops are ignored
      add_request(deq_pkg::OP_POP_BACK, $urandom, deq_pkg::POS_W'($urandom));
      add_request(deq_pkg::OP_POP_FRONT, $urandom, deq_pkg::POS_W'($urandom));
      add_request(deq_pkg::OP_READ, $urandom, '0);
      add_request(OP_SPARE_LO, $urandom, deq_pkg::POS_W'($urandom));
      add_request(OP_SPARE_HI, $urandom, deq_pkg::POS_W'($urandom));
      // Fill from both ends, then push into a full queue
      for (int i = 0; i < deq_pkg::ENTRIES; i++) begin
         add_request(i[0] ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK,
                     (i < 4) ? edge_words[i] : $urandom,
                     deq_pkg::POS_W'($urandom));
      end
      add_request(deq_pkg::OP_PUSH_BACK, $urandom, deq_pkg::POS_W'($urandom));
      add_request(deq_pkg::OP_PUSH_FRONT, $urandom, deq_pkg::POS_W'($urandom));
      add_request(deq_pkg::OP_READ, $urandom, deq_pkg::POS_W'(POS_MAX));
      add_request(deq_pkg::OP_READ, $urandom, '0);
      add_request(deq_pkg::OP_POP_BACK, $urandom, deq_pkg::POS_W'($urandom));
      add_request(deq_pkg::OP_POP_FRONT, $urandom, deq_pkg::POS_W'($urandom));

      // Random walk that alternates between filling and draining
      filling = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if ($urandom_range(0, 39) == 0) begin
            filling = !filling;
         end
         r = $urandom_range(0, 99);
         if (r < 4) begin
            add_request(deq_pkg::OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)),
                        $urandom, deq_pkg::POS_W'($urandom));
         end else if (r < 26) begin
            if (plan_count == 0 || $urandom_range(0, 7) == 0) begin
               pos = deq_pkg::POS_W'($urandom_range(0, POS_MAX));
            end else begin
               pos = deq_pkg::POS_W'($urandom_range(0, plan_count - 1));
            end
            add_request(deq_pkg::OP_READ, $urandom, pos);
         end else if ($urandom_range(0, 99) < (filling ? 75 : 25)) begin
            add_request($urandom_range(0, 1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK,
                        $urandom, deq_pkg::POS_W'($urandom));
         end else begin
            add_request($urandom_range(0, 1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK,
                        $urandom, deq_pkg::POS_W'($urandom));
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (requests_left.size() > 0 || req_valid || answers_due.size() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && answers_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
